FILE: design/assert_macros.svh
// Assertion helpers used by the checker file cspc_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge; hold off while reset is low.
`define CSPC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal keeps its value in the cycle after a condition holds.
`define CSPC_ASSERT_STABLE(lbl, clk, rst_n, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: design/cspc_pkg.sv
package cspc_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Register select, taken from address bits 3..1
  typedef enum logic [2:0] {
    REG_DATA_LO = 3'd0,
    REG_DATA_HI = 3'd1,
    REG_STATUS  = 3'd2,
    REG_MODE    = 3'd4,
    REG_CONTROL = 3'd5,
    REG_BAUD    = 3'd7
  } reg_sel_t;

  localparam logic [5:0]  DSR_ACTIVE_TICKS = 6'd32;
  localparam logic [21:0] MIN_BIT_PERIOD   = 22'd32;

  localparam logic [8:0]  MODE_WR_MASK = 9'h13F;
  localparam logic [13:0] CTRL_WR_MASK = 14'h3F2F;

  // Baud scale per mode[1:0]
  localparam logic [2:0] SCALE_TAB [4] = '{3'd0, 3'd0, 3'd4, 3'd6};

  // Control bits
  localparam int CTRL_TX_EN    = 0;
  localparam int CTRL_DTR      = 1;
  localparam int CTRL_RX_EN    = 2;
  localparam int CTRL_IRQ_ACK  = 4;
  localparam int CTRL_SOFT_RST = 6;
  localparam int CTRL_TX_IRQ   = 10;
  localparam int CTRL_RX_IRQ   = 11;
  localparam int CTRL_DSR_IRQ  = 12;
  localparam int CTRL_PORT_B   = 13;

  // Flag bits
  localparam int F_TXP = 0;
  localparam int F_RXP = 1;
  localparam int F_TXB = 2;
  localparam int F_RXB = 3;
  localparam int F_AVL = 4;
  localparam int F_IRQ = 5;

  // Status bits
  localparam int STAT_TX_IDLE = 0;
  localparam int STAT_RX_AVL  = 1;
  localparam int STAT_DSR     = 7;
  localparam int STAT_IRQ     = 9;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  address;
    logic [15:0] write_data;
    logic        rx_bit;
    logic        dsr_event_a;
    logic        dsr_event_b;
  } cspc_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_level;
    logic        select_a;
    logic        select_b;
    logic        bit_strobe;
    logic        tx_bit;
  } cspc_result_t;

  typedef struct packed {
    logic [21:0]      divider;
    logic [8:0]       mode;
    logic [13:0]      ctrl;
    logic [15:0]      baud;
    logic [7:0]       tx_shift;
    logic [7:0]       rx_shift;
    logic [2:0]       tx_count;
    logic [2:0]       rx_count;
    logic [5:0]       flags;
    logic [1:0][5:0]  dsr_win;
  } cspc_state_t;

endpackage

FILE: design/cspc_req_if.sv
interface cspc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [3:0]  address;
  logic [15:0] write_data;
  logic        rx_bit;
  logic        dsr_event_a;
  logic        dsr_event_b;

  modport source (
    output valid, kind, address, write_data, rx_bit, dsr_event_a, dsr_event_b,
    input  ready
  );
  modport sink (
    input  valid, kind, address, write_data, rx_bit, dsr_event_a, dsr_event_b,
    output ready
  );
endinterface

FILE: design/cspc_rsp_if.sv
interface cspc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;
  logic        select_a;
  logic        select_b;
  logic        bit_strobe;
  logic        tx_bit;

  modport source (
    output valid, read_data, irq_level, select_a, select_b, bit_strobe, tx_bit,
    input  ready
  );
  modport sink (
    input  valid, read_data, irq_level, select_a, select_b, bit_strobe, tx_bit,
    output ready
  );
endinterface

FILE: design/cspc_in_stage.sv
module cspc_in_stage (
  input  logic                clk,
  input  logic                rst_n,
  cspc_req_if.sink            in_req,
  input  logic                advance,
  output logic                item_valid,
  output cspc_pkg::cspc_item_t item
);
  import cspc_pkg::*;

  logic       item_valid_r;
  cspc_item_t item_r;

  // Take a new request whenever the register is empty or drains this cycle.
  assign in_req.ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      item_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      item_r.kind        <= in_req.kind;
      item_r.address     <= in_req.address;
      item_r.write_data  <= in_req.write_data;
      item_r.rx_bit      <= in_req.rx_bit;
      item_r.dsr_event_a <= in_req.dsr_event_a;
      item_r.dsr_event_b <= in_req.dsr_event_b;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;
endmodule

FILE: design/cspc_core.sv
module cspc_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  cspc_pkg::cspc_item_t  item,
  output cspc_pkg::cspc_result_t result
);
  import cspc_pkg::*;

  cspc_state_t state_r;
  cspc_state_t state_nxt;

  function automatic logic [21:0] bit_period(cspc_state_t st);
    logic [21:0] p;
    p = ({6'd0, st.baud} << SCALE_TAB[st.mode[1:0]]) & ~22'd1;
    if (p < MIN_BIT_PERIOD) begin
      p = MIN_BIT_PERIOD;
    end
    return p;
  endfunction

  function automatic logic sel_a(logic [13:0] ctrl);
    return ctrl[CTRL_DTR] && !ctrl[CTRL_PORT_B];
  endfunction

  function automatic logic sel_b(logic [13:0] ctrl);
    return ctrl[CTRL_DTR] && ctrl[CTRL_PORT_B];
  endfunction

  // Launch queued directions, drop busy flags when both sides are disabled, and clear the divider when neither is busy.
  function automatic cspc_state_t start_stop(cspc_state_t st);
    cspc_state_t r;
    logic        go;
    r  = st;
    go = (r.flags[F_RXP] && r.ctrl[CTRL_RX_EN]) || (r.flags[F_TXP] && r.ctrl[CTRL_TX_EN]);
    if (go) begin
      if (r.flags[F_RXP]) begin
        r.flags[F_RXP] = 1'b0;
        r.flags[F_AVL] = 1'b0;
        r.flags[F_RXB] = 1'b1;
        r.rx_shift     = 8'd0;
        r.rx_count     = 3'd0;
      end
      if (r.flags[F_TXP]) begin
        r.flags[F_TXP] = 1'b0;
        r.flags[F_TXB] = 1'b1;
        r.tx_count     = 3'd0;
      end
      r.divider = bit_period(r);
    end
    if (!r.ctrl[CTRL_TX_EN] && !r.ctrl[CTRL_RX_EN]) begin
      r.flags[F_RXB] = 1'b0;
      r.flags[F_TXB] = 1'b0;
    end
    if (!r.flags[F_RXB] && !r.flags[F_TXB]) begin
      r.divider = 22'd0;
    end
    return r;
  endfunction

  function automatic logic [5:0] dsr_next(logic [5:0] win, logic ev, logic selected);
    logic [5:0] w;
    w = win;
    if (ev && selected) begin
      w = DSR_ACTIVE_TICKS;
    end else if (w != 6'd0) begin
      w = w - 6'd1;
    end
    return w;
  endfunction

  always_comb begin
    cspc_state_t s;
    logic [31:0] rd;
    logic [23:0] v;
    logic        strobe;
    logic        txd;
    logic        done;

    s      = state_r;
    rd     = 32'd0;
    strobe = 1'b0;
    txd    = 1'b0;
    done   = 1'b0;
    v      = {8'd0, item.write_data} << {item.address[0], 3'b000};

    case (kind_t'(item.kind))
      KIND_TICK: begin
        s.dsr_win[0] = dsr_next(state_r.dsr_win[0], item.dsr_event_a, sel_a(state_r.ctrl));
        s.dsr_win[1] = dsr_next(state_r.dsr_win[1], item.dsr_event_b, sel_b(state_r.ctrl));
        if ((item.dsr_event_a && sel_a(state_r.ctrl)) ||
            (item.dsr_event_b && sel_b(state_r.ctrl))) begin
          if (s.ctrl[CTRL_DSR_IRQ]) begin
            s.flags[F_IRQ] = 1'b1;
          end
        end
        if (s.divider != 22'd0) begin
          s.divider = s.divider - 22'd1;
          if (s.divider == 22'd0 && (s.flags[F_TXB] || s.flags[F_RXB])) begin
            strobe = 1'b1;
            if (s.flags[F_TXB]) begin
              txd        = s.tx_shift[s.tx_count];
              s.tx_count = s.tx_count + 3'd1;
              if (s.tx_count == 3'd0) begin
                done           = 1'b1;
                s.flags[F_TXB] = 1'b0;
                if (s.ctrl[CTRL_TX_IRQ]) begin
                  s.flags[F_IRQ] = 1'b1;
                end
              end
            end
            if (s.flags[F_RXB]) begin
              s.rx_shift[s.rx_count] = item.rx_bit;
              s.rx_count             = s.rx_count + 3'd1;
              if (s.rx_count == 3'd0) begin
                done           = 1'b1;
                s.flags[F_RXB] = 1'b0;
                s.flags[F_AVL] = 1'b1;
                if (s.ctrl[CTRL_RX_IRQ]) begin
                  s.flags[F_IRQ] = 1'b1;
                end
              end
            end
            s.divider = bit_period(s);
            if (done) begin
              s = start_stop(s);
            end
          end
        end
      end

      KIND_WRITE: begin
        case (reg_sel_t'(item.address[3:1]))
          REG_DATA_LO, REG_DATA_HI: begin
            // Any lane but the lowest shifts the byte out of reach.
            s.tx_shift     = (item.address[1:0] == 2'd0) ? item.write_data[7:0] : 8'd0;
            s.flags[F_TXP] = 1'b1;
            s.flags[F_TXB] = 1'b0;
          end
          REG_MODE: begin
            s.mode = v[8:0] & MODE_WR_MASK;
          end
          REG_CONTROL: begin
            s.ctrl = v[13:0] & CTRL_WR_MASK;
            if (v[CTRL_IRQ_ACK]) begin
              s.flags[F_IRQ] = 1'b0;
            end
            if (v[CTRL_SOFT_RST]) begin
              s = '0;
            end
            if (!sel_a(s.ctrl)) begin
              s.dsr_win[0] = 6'd0;
            end
            if (!sel_b(s.ctrl)) begin
              s.dsr_win[1] = 6'd0;
            end
          end
          REG_BAUD: begin
            s.baud = v[15:0];
          end
          default: begin
          end
        endcase
        s = start_stop(s);
      end

      KIND_READ: begin
        case (reg_sel_t'(item.address[3:1]))
          REG_DATA_LO, REG_DATA_HI: begin
            rd             = {4{state_r.rx_shift}};
            s.flags[F_AVL] = 1'b0;
            s.flags[F_RXB] = 1'b0;
            s.flags[F_RXP] = 1'b1;
            s              = start_stop(s);
            rd             = rd >> {item.address[1], 4'b0000};
          end
          REG_STATUS: begin
            rd[STAT_TX_IDLE] = !(state_r.flags[F_TXP] || state_r.flags[F_TXB]);
            rd[STAT_RX_AVL]  = state_r.flags[F_AVL];
            rd[STAT_DSR]     = (state_r.dsr_win[0] != 6'd0) || (state_r.dsr_win[1] != 6'd0);
            rd[STAT_IRQ]     = state_r.flags[F_IRQ];
          end
          REG_MODE:    rd = {23'd0, state_r.mode};
          REG_CONTROL: rd = {18'd0, state_r.ctrl};
          REG_BAUD:    rd = {16'd0, state_r.baud};
          default: begin
          end
        endcase
        rd = rd >> {item.address[0], 3'b000};
      end

      default: begin
      end
    endcase

    state_nxt         = s;
    result.read_data  = rd;
    result.irq_level  = s.flags[F_IRQ];
    result.select_a   = sel_a(s.ctrl);
    result.select_b   = sel_b(s.ctrl);
    result.bit_strobe = strobe;
    result.tx_bit     = txd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
    end
  end
endmodule

FILE: design/cspc_out_stage.sv
module cspc_out_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  cspc_pkg::cspc_result_t result,
  output logic                   free,
  cspc_rsp_if.source             out_rsp
);
  import cspc_pkg::*;

  logic         out_valid_r;
  cspc_result_t out_data_r;

  // The register can take a result when empty or when its result leaves now.
  assign free = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (free) begin
      out_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      out_data_r <= result;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.read_data  = out_data_r.read_data;
  assign out_rsp.irq_level  = out_data_r.irq_level;
  assign out_rsp.select_a   = out_data_r.select_a;
  assign out_rsp.select_b   = out_data_r.select_b;
  assign out_rsp.bit_strobe = out_data_r.bit_strobe;
  assign out_rsp.tx_bit     = out_data_r.tx_bit;
endmodule

FILE: design/console_serial_port_controller_unit.sv
// Serial port controller: bus reads/writes and bit-clock ticks, one request per cycle
// when not stalled. Path: the input register, then the result register.
// Throughput: 1 request per cycle unless stalled; cspc_core updates its state per request.
// Reset: synchronous, active-low rst_n clears the core state: flags, counters and DSR windows.
// Pipeline registers drop their valid bits on reset; no clearing pass is needed.
module console_serial_port_controller_unit (
  input  logic       clk,
  input  logic       rst_n,
  cspc_req_if.sink   in_req,
  cspc_rsp_if.source out_rsp
);
  import cspc_pkg::*;

  cspc_item_t   item;
  cspc_result_t result;
  logic         item_valid;
  logic         out_free;
  logic         advance;

  // Advance the held request into the result register whenever that register
  // is empty or its result is taken in this cycle. The state update happens
  // on the same edge, so each request sees all effects of the one before it.
  assign advance = item_valid && out_free;

  // Input register: holds one request; refills as it drains.
  cspc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Register file, shift registers, divider, DSR windows and the per-request
  // next-state logic: tick, bus write or bus read.
  cspc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  // Result register: hold a result while the consumer stalls. With both
  // registers full, the input side stalls until the result is taken.
  cspc_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (advance),
    .result  (result),
    .free    (out_free),
    .out_rsp (out_rsp)
  );
endmodule

FILE: design/cspc_checker.sv
`include "assert_macros.svh"

module cspc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [36:0] out_payload,
  input logic        select_a,
  input logic        select_b
);
  `CSPC_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `CSPC_ASSERT_STABLE(a_out_stable, clk, rst_n, out_valid && !out_ready, out_payload, "result changed while stalled")
  `CSPC_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "request side stalled with empty result")
  `CSPC_ASSERT(a_one_port, clk, rst_n, out_valid |-> !(select_a && select_b), "both ports selected")
endmodule

bind console_serial_port_controller_unit cspc_checker u_cspc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .out_payload ({out_rsp.read_data, out_rsp.irq_level, out_rsp.select_a, out_rsp.select_b,
                 out_rsp.bit_strobe, out_rsp.tx_bit}),
  .select_a    (out_rsp.select_a),
  .select_b    (out_rsp.select_b)
);
